// ----- rtl/block_buffer_cache_tags_defines.svh -----
// Assertion macros shared by the buffer cache tag RTL
`ifndef BLOCK_BUFFER_CACHE_TAGS_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_TAGS_DEFINES_SVH
// Check that a condition implies a consequence on the same edge
`define BBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that a condition implies a consequence on the next edge
`define BBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/bbc_tags_pkg.sv -----
// Package with constants, codes and cell interface types for the tag cache
package bbc_tags_pkg;
  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW    = $clog2(Entries);

  typedef logic [IdxW-1:0] idx_t;

  // Result status codes
  localparam logic [2:0] StHit   = 3'd0;
  localparam logic [2:0] StMiss  = 3'd1;
  localparam logic [2:0] StNone  = 3'd2;
  localparam logic [2:0] StRel   = 3'd3;
  localparam logic [2:0] StFreed = 3'd4;
  localparam logic [2:0] StMark  = 3'd5;
  localparam logic [2:0] StBad   = 3'd6;

  // Request modes
  localparam logic [1:0] ModeGet     = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModeMark    = 2'd2;

  typedef enum logic [1:0] {
    SIdle,
    SSearch,
    SApply,
    SOut
  } state_e;

  // One list position: entry index and that entry's tag state
  typedef struct packed {
    idx_t        idx;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [16:0] size;
    logic [7:0]  refs;
    logic        vld;
  } cell_t;

  // Command from the controller to every cell
  typedef struct packed {
    logic        update;   // write the target entry
    idx_t        target;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [16:0] size;
    logic [7:0]  refs;
    logic        vld;
    logic        shift;    // move target to tail, cells behind it shift toward head
  } cmd_t;
endpackage

// ----- rtl/bbc_tags_cell.sv -----
// One list position of the tag chain: holds an entry and shifts toward head
module bbc_tags_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbc_tags_pkg::idx_t reset_idx_i,
  input  logic               is_tail_i,
  input  bbc_tags_pkg::cmd_t cmd_i,
  input  logic               pass_i,     // some cell before here holds target
  input  bbc_tags_pkg::cell_t next_i,    // neighbor toward the tail
  output bbc_tags_pkg::cell_t cell_o,
  output logic               hit_o,
  output logic               pass_o
);
  import bbc_tags_pkg::*;

  cell_t cell_q, cell_d, upd;
  logic  is_tgt;

  assign is_tgt = (cell_q.idx == cmd_i.target);
  assign pass_o = pass_i | is_tgt;
  assign cell_o = cell_q;
  assign hit_o  = (cell_q.dev == cmd_i.dev) && (cell_q.blk == cmd_i.blk);

  // Apply the update, then shift along the chain on a move
  always_comb begin
    upd = cell_q;
    if (cmd_i.update && is_tgt) begin
      upd.dev  = cmd_i.dev;
      upd.blk  = cmd_i.blk;
      upd.size = cmd_i.size;
      upd.refs = cmd_i.refs;
      upd.vld  = cmd_i.vld;
    end
    cell_d = upd;
    if (cmd_i.shift && pass_o) begin
      if (is_tail_i) begin
        cell_d      = '0;
        cell_d.idx  = cmd_i.target;
      end else begin
        cell_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q     <= '0;
      cell_q.idx <= reset_idx_i;
    end else begin
      cell_q <= cell_d;
    end
  end
endmodule

// ----- rtl/block_buffer_cache_tags.sv -----
// Buffer cache tag manager: chain of list cells plus request controller
//
// Input channel: in_valid_i / in_stall_o with mode, device, block_number,
// block_size and entry. Output channel: out_valid_o / out_stall_i with
// status, slot, needs_read and holders, one result per request.
// Each request passes through accept, search across the cell chain (all
// cells compare in parallel, a priority pick finds the head-most hit and
// the tail-most free entry, or the named entry's cell for a release or a
// mark), and update with an optional shift of the chain toward the head,
// which also loads the result register. The result beat can leave on the
// edge after the update. The next request is taken while the result beat
// waits in the output register, but not before the last one has left its
// update step. The cell chain holds the list order; each cell carries its
// entry's tags and holder count. Reset puts entries in ascending order with
// all tags and counts at zero. While the receiver stalls, the result holds
// and a finished request blocks the next from leaving its update step.
module block_buffer_cache_tags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [16:0] block_size_i,
  input  logic [5:0]  entry_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  slot_o,
  output logic        needs_read_o,
  output logic [7:0]  holders_o
);
  import bbc_tags_pkg::*;
  `include "block_buffer_cache_tags_defines.svh"

  state_e state_q, state_d;
  logic [1:0]  mode_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [16:0] size_q;
  logic [5:0]  ent_q;

  cell_t cells [Entries];
  logic  hits  [Entries];
  logic  pass  [Entries+1];
  cmd_t  cmd;

  // Search results registered between steps
  logic  hit_q, hit_d, free_q, free_d;
  cell_t pick_q, pick_d;
  cell_t ent_cell;

  logic       ov_q, ov_d;
  logic [2:0] st_q, st_d;
  logic [5:0] sl_q, sl_d;
  logic       nr_q, nr_d;
  logic [7:0] ho_q, ho_d;

  // Cell chain
  assign pass[0] = 1'b0;
  for (genvar g = 0; g < Entries; g++) begin : g_cell
    cell_t nxt;
    if (g == Entries - 1) begin : g_t
      assign nxt = '0;
    end else begin : g_n
      assign nxt = cells[g+1];
    end
    bbc_tags_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .reset_idx_i(idx_t'(g)),
      .is_tail_i  (g == Entries - 1),
      .cmd_i      (cmd),
      .pass_i     (pass[g]),
      .next_i     (nxt),
      .cell_o     (cells[g]),
      .hit_o      (hits[g]),
      .pass_o     (pass[g+1])
    );
  end

  // Priority pick: head-most hit, tail-most free, cell of the named entry
  always_comb begin
    hit_d    = 1'b0;
    free_d   = 1'b0;
    pick_d   = '0;
    ent_cell = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_d  = 1'b1;
        pick_d = cells[i];
      end
    end
    if (!hit_d) begin
      for (int i = 0; i < Entries; i++) begin
        if (cells[i].refs == 8'd0) begin
          free_d = 1'b1;
          pick_d = cells[i];
        end
      end
    end
    for (int i = 0; i < Entries; i++) begin
      if (cells[i].idx == idx_t'(ent_q)) ent_cell = cells[i];
    end
    if (mode_q != ModeGet) pick_d = ent_cell;
  end

  // Controller
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.target = pick_q.idx;
    cmd.dev  = pick_q.dev;
    cmd.blk  = pick_q.blk;
    cmd.size = pick_q.size;
    cmd.refs = pick_q.refs;
    cmd.vld  = pick_q.vld;
    ov_d = ov_q && out_stall_i;
    st_d = st_q;
    sl_d = sl_q;
    nr_d = nr_q;
    ho_d = ho_q;
    in_stall_o = (state_q != SIdle);
    unique case (state_q)
      SIdle: if (in_valid_i) state_d = SSearch;
      SSearch: begin
        // Present the requested tag to every cell for the compare
        cmd.dev = dev_q;
        cmd.blk = blk_q;
        state_d = SApply;
      end
      SApply: begin
        if (!ov_d) begin
          state_d = SIdle;
          ov_d = 1'b1;
          nr_d = 1'b0;
          ho_d = 8'd0;
          sl_d = 6'd0;
          if (mode_q == ModeGet) begin
            if (dev_q == 8'd0) begin
              st_d = StBad;
            end else if (hit_q) begin
              cmd.update = 1'b1;
              cmd.size   = size_q;
              if (pick_q.refs != 8'hff) cmd.refs = pick_q.refs + 8'd1;
              st_d = StHit;
            end else if (free_q) begin
              cmd.update = 1'b1;
              cmd.dev  = dev_q;
              cmd.blk  = blk_q;
              cmd.size = size_q;
              cmd.refs = 8'd1;
              cmd.vld  = 1'b0;
              st_d = StMiss;
            end else begin
              st_d = StNone;
            end
          end else if (mode_q == ModeRelease && pick_q.refs != 8'd0) begin
            cmd.update = 1'b1;
            cmd.refs   = pick_q.refs - 8'd1;
            if (cmd.refs == 8'd0) begin
              cmd.dev = '0; cmd.blk = '0; cmd.size = '0; cmd.vld = 1'b0;
              cmd.shift = 1'b1;
              st_d = StFreed;
            end else begin
              st_d = StRel;
            end
          end else if (mode_q == ModeMark && pick_q.refs != 8'd0) begin
            cmd.update = 1'b1;
            cmd.vld    = 1'b1;
            st_d = StMark;
          end else begin
            st_d = StBad;
          end
          if (cmd.update) begin
            sl_d = 6'(cmd.target);
            nr_d = !cmd.vld;
            ho_d = cmd.refs;
          end
        end
      end
      SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Request, search and result registers
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      mode_q <= mode_i;
      dev_q  <= device_i;
      blk_q  <= block_number_i;
      size_q <= block_size_i;
      ent_q  <= entry_i;
    end
    if (state_q == SSearch) begin
      hit_q  <= hit_d;
      free_q <= free_d;
      pick_q <= pick_d;
    end
    st_q <= st_d;
    sl_q <= sl_d;
    nr_q <= nr_d;
    ho_q <= ho_d;
  end

  assign out_valid_o  = ov_q;
  assign status_o     = st_q;
  assign slot_o       = sl_q;
  assign needs_read_o = nr_q;
  assign holders_o    = ho_q;

  `BBC_ASSERT_IMP(a_stall_busy, clk_i, rst_ni, state_q == SSearch, in_stall_o)
  `BBC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o && $stable(status_o) && $stable(holders_o))
  `BBC_ASSERT_IMP(a_shift_free, clk_i, rst_ni, cmd.shift, cmd.refs == 8'd0)
  `BBC_ASSERT_NXT(a_accept_search, clk_i, rst_ni,
                  state_q == SIdle && in_valid_i, state_q == SSearch)
endmodule
